@@ rtl/core/swsr_pkg.sv @@
// Shared types, codes and reset values for the single-wire sensor reader.
// Used by swsr_cfg, swsr_fsm and single_wire_sensor_reader; no dependencies.

package swsr_pkg;

    // Widths of the configuration registers.
    localparam int unsigned START_W  = 16;
    localparam int unsigned DELAY_W  = 8;
    localparam int unsigned BYTES_W  = 4;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned APB_W    = 32;

    // Register indexes, one word apart on the bus.
    localparam logic [2:0] REG_START_LOW     = 3'd0;
    localparam logic [2:0] REG_FIRST_SAMPLE  = 3'd1;
    localparam logic [2:0] REG_SECOND_SAMPLE = 3'd2;
    localparam logic [2:0] REG_BIT_SAMPLE    = 3'd3;
    localparam logic [2:0] REG_BYTES         = 3'd4;
    localparam logic [2:0] REG_WAIT_LIMIT    = 3'd5;

    // Register reset values.
    localparam logic [START_W-1:0] START_LOW_RST     = 16'd18000;
    localparam logic [DELAY_W-1:0] FIRST_SAMPLE_RST  = 8'd40;
    localparam logic [DELAY_W-1:0] SECOND_SAMPLE_RST = 8'd80;
    localparam logic [DELAY_W-1:0] BIT_SAMPLE_RST    = 8'd40;
    localparam logic [BYTES_W-1:0] BYTES_RST         = 4'd5;
    localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST    = 16'd0;

    // Most bytes a transaction can carry.
    localparam logic [BYTES_W-1:0] BYTES_MAX = 4'd8;

    // Status codes.
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_NO_RESP   = 3'd2;
    localparam logic [2:0] ST_BAD       = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;

    // Transaction phases.
    typedef enum logic [7:0] {
        PH_IDLE        = 8'b0000_0001,
        PH_START_LOW   = 8'b0000_0010,
        PH_WAIT_FIRST  = 8'b0000_0100,
        PH_WAIT_SECOND = 8'b0000_1000,
        PH_RESP_LOW    = 8'b0001_0000,
        PH_WAIT_HIGH   = 8'b0010_0000,
        PH_WAIT_SAMPLE = 8'b0100_0000,
        PH_WAIT_LOW    = 8'b1000_0000
    } phase_t;

    // Configuration as seen by the state machine.
    typedef struct packed {
        logic [START_W-1:0] start_low_ticks;
        logic [DELAY_W-1:0] first_sample_ticks;
        logic [DELAY_W-1:0] second_sample_ticks;
        logic [DELAY_W-1:0] bit_sample_ticks;
        logic [BYTES_W-1:0] bytes_to_read;
        logic [LIMIT_W-1:0] wait_limit_ticks;
    } cfg_t;

    // One result word.
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       byte_last;
        logic       status_valid;
        logic [2:0] status;
    } result_t;

endpackage

@@ rtl/core/swsr_cfg.sv @@
// Configuration register bank of the single-wire sensor reader, APB-style port.
// Depends on swsr_pkg.

module swsr_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swsr_pkg::ADDR_W-1:0] paddr,
    input  logic [swsr_pkg::APB_W-1:0]  pwdata,
    output logic [swsr_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    output swsr_pkg::cfg_t              cfg
);

    swsr_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register writes; unused addresses are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks     <= swsr_pkg::START_LOW_RST;
            cfg_reg.first_sample_ticks  <= swsr_pkg::FIRST_SAMPLE_RST;
            cfg_reg.second_sample_ticks <= swsr_pkg::SECOND_SAMPLE_RST;
            cfg_reg.bit_sample_ticks    <= swsr_pkg::BIT_SAMPLE_RST;
            cfg_reg.bytes_to_read       <= swsr_pkg::BYTES_RST;
            cfg_reg.wait_limit_ticks    <= swsr_pkg::WAIT_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                swsr_pkg::REG_START_LOW:
                    cfg_reg.start_low_ticks <= pwdata[swsr_pkg::START_W-1:0];
                swsr_pkg::REG_FIRST_SAMPLE:
                    cfg_reg.first_sample_ticks <= pwdata[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_SECOND_SAMPLE:
                    cfg_reg.second_sample_ticks <= pwdata[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_BIT_SAMPLE:
                    cfg_reg.bit_sample_ticks <= pwdata[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_BYTES:
                    cfg_reg.bytes_to_read <= pwdata[swsr_pkg::BYTES_W-1:0];
                swsr_pkg::REG_WAIT_LIMIT:
                    cfg_reg.wait_limit_ticks <= pwdata[swsr_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            swsr_pkg::REG_START_LOW:
                prdata = {16'd0, cfg_reg.start_low_ticks};
            swsr_pkg::REG_FIRST_SAMPLE:
                prdata = {24'd0, cfg_reg.first_sample_ticks};
            swsr_pkg::REG_SECOND_SAMPLE:
                prdata = {24'd0, cfg_reg.second_sample_ticks};
            swsr_pkg::REG_BIT_SAMPLE:
                prdata = {24'd0, cfg_reg.bit_sample_ticks};
            swsr_pkg::REG_BYTES:
                prdata = {28'd0, cfg_reg.bytes_to_read};
            swsr_pkg::REG_WAIT_LIMIT:
                prdata = {16'd0, cfg_reg.wait_limit_ticks};
            default: prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/swsr_fsm.sv @@
// Link state machine: holds the transaction state and works out one tick's
// result and next state. Depends on swsr_pkg.

module swsr_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    input  swsr_pkg::cfg_t      cfg,
    input  logic                step,        // a tick word moves to the output register
    input  logic                action,
    input  logic                line_level,
    output swsr_pkg::result_t   result
);

    swsr_pkg::phase_t               phase_reg, phase_next;
    logic [swsr_pkg::COUNT_W-1:0]   tick_count_reg, tick_count_next;
    logic [2:0]                     bit_index_reg, bit_index_next;
    logic [2:0]                     byte_index_reg, byte_index_next;
    logic [7:0]                     shift_byte_reg, shift_byte_next;

    logic [swsr_pkg::COUNT_W-1:0]   tick_inc;
    logic [swsr_pkg::COUNT_W-1:0]   tick_sat;
    logic                           expired;
    logic                           bit_done;
    logic [2:0]                     bit_inc;
    logic [swsr_pkg::BYTES_W-1:0]   byte_count;
    logic [swsr_pkg::BYTES_W-1:0]   byte_pos;

    // Shared counter arithmetic.
    assign tick_inc = tick_count_reg + 16'd1;
    assign tick_sat = (tick_count_reg == 16'hFFFF) ? tick_count_reg : tick_inc;
    assign expired  = (cfg.wait_limit_ticks != '0) && (tick_sat >= cfg.wait_limit_ticks);
    assign bit_inc  = bit_index_reg + 3'd1;
    assign byte_pos = {1'b0, byte_index_reg} + 4'd1;

    // Byte count clamped to one through eight.
    always_comb begin
        if (cfg.bytes_to_read == '0) begin
            byte_count = 4'd1;
        end else if (cfg.bytes_to_read > swsr_pkg::BYTES_MAX) begin
            byte_count = swsr_pkg::BYTES_MAX;
        end else begin
            byte_count = cfg.bytes_to_read;
        end
    end

    // Next state and result for the current tick.
    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        byte_index_next = byte_index_reg;
        shift_byte_next = shift_byte_reg;
        bit_done        = 1'b0;
        result          = '0;
        result.busy_res = (phase_reg != swsr_pkg::PH_IDLE);

        unique case (phase_reg)
            swsr_pkg::PH_IDLE: begin
                if (action) begin
                    result.busy_res  = 1'b1;
                    result.drive_low = 1'b1;
                    phase_next       = swsr_pkg::PH_START_LOW;
                    tick_count_next  = 16'd1;
                    bit_index_next   = '0;
                    byte_index_next  = '0;
                    shift_byte_next  = '0;
                end
            end
            swsr_pkg::PH_START_LOW: begin
                if (tick_count_reg < cfg.start_low_ticks) begin
                    result.drive_low = 1'b1;
                    tick_count_next  = tick_inc;
                end else begin
                    phase_next      = swsr_pkg::PH_WAIT_FIRST;
                    tick_count_next = '0;
                end
            end
            swsr_pkg::PH_WAIT_FIRST: begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, cfg.first_sample_ticks}) begin
                    if (line_level) begin
                        result.status_valid = 1'b1;
                        result.status       = swsr_pkg::ST_NO_RESP;
                        phase_next          = swsr_pkg::PH_IDLE;
                    end else begin
                        phase_next      = swsr_pkg::PH_WAIT_SECOND;
                        tick_count_next = '0;
                    end
                end
            end
            swsr_pkg::PH_WAIT_SECOND: begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, cfg.second_sample_ticks}) begin
                    result.status_valid = 1'b1;
                    if (line_level) begin
                        result.status   = swsr_pkg::ST_OK;
                        phase_next      = swsr_pkg::PH_RESP_LOW;
                        tick_count_next = '0;
                    end else begin
                        result.status = swsr_pkg::ST_BAD;
                        phase_next    = swsr_pkg::PH_IDLE;
                    end
                end
            end
            swsr_pkg::PH_RESP_LOW: begin
                if (!line_level) begin
                    phase_next      = swsr_pkg::PH_WAIT_HIGH;
                    tick_count_next = '0;
                end else begin
                    tick_count_next = tick_sat;
                    if (expired) begin
                        result.status_valid = 1'b1;
                        result.status       = swsr_pkg::ST_TIMEOUT;
                        phase_next          = swsr_pkg::PH_IDLE;
                    end
                end
            end
            swsr_pkg::PH_WAIT_HIGH: begin
                if (line_level) begin
                    phase_next      = swsr_pkg::PH_WAIT_SAMPLE;
                    tick_count_next = '0;
                end else begin
                    tick_count_next = tick_sat;
                    if (expired) begin
                        result.status_valid = 1'b1;
                        result.status       = swsr_pkg::ST_TIMEOUT;
                        phase_next          = swsr_pkg::PH_IDLE;
                    end
                end
            end
            swsr_pkg::PH_WAIT_SAMPLE: begin
                tick_count_next = tick_inc;
                if (tick_inc >= {8'd0, cfg.bit_sample_ticks}) begin
                    shift_byte_next = {shift_byte_reg[6:0], line_level};
                    if (!line_level) begin
                        bit_done = 1'b1;
                    end else begin
                        phase_next      = swsr_pkg::PH_WAIT_LOW;
                        tick_count_next = '0;
                    end
                end
            end
            swsr_pkg::PH_WAIT_LOW: begin
                if (!line_level) begin
                    bit_done = 1'b1;
                end else begin
                    tick_count_next = tick_sat;
                    if (expired) begin
                        result.status_valid = 1'b1;
                        result.status       = swsr_pkg::ST_TIMEOUT;
                        phase_next          = swsr_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                phase_next = swsr_pkg::PH_IDLE;
            end
        endcase

        // Bit completion: count bits, emit a byte after every eighth.
        if (bit_done) begin
            bit_index_next = bit_inc;
            if (bit_inc == 3'd0) begin
                result.byte_valid = 1'b1;
                result.data_byte  = shift_byte_next;
                shift_byte_next   = '0;
                if (byte_pos >= byte_count) begin
                    result.byte_last = 1'b1;
                    byte_index_next  = '0;
                    phase_next       = swsr_pkg::PH_IDLE;
                end else begin
                    byte_index_next = byte_pos[2:0];
                    phase_next      = swsr_pkg::PH_WAIT_HIGH;
                    tick_count_next = '0;
                end
            end else begin
                phase_next      = swsr_pkg::PH_WAIT_HIGH;
                tick_count_next = '0;
            end
        end
    end

    // State registers advance once per tick word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= swsr_pkg::PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            byte_index_reg <= '0;
            shift_byte_reg <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            byte_index_reg <= byte_index_next;
            shift_byte_reg <= shift_byte_next;
        end
    end

endmodule

@@ rtl/core/single_wire_sensor_reader.sv @@
// Top level of the single-wire sensor reader: input and output registers,
// configuration bank and link state machine. Depends on swsr_pkg, swsr_cfg, swsr_fsm.

// One input word is one microsecond tick and gives exactly one result word.
// Words flow at one per clock while m_tready keeps the output register free: an
// input register feeds the state machine, whose result is caught in an output
// register. A tick word's result moves from the input register side into the
// output register once that register is free. While a result waits, the input register
// still takes one more word, and then the input side stalls. The rate is set
// by the state register loop, which advances once per tick word.
// The user must write configuration through the APB port only while no tick
// words are in flight; the block itself does not enforce this.
module single_wire_sensor_reader (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Tick input.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] line_level, [7:1] zero
    input  logic                        s_tuser,   // [0] action
    // Result output.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [0] drive_low, [1] busy_res,
                                                   // [2] byte_valid, [10:3] data_byte,
                                                   // [11] status_valid, [14:12] status,
                                                   // [15] zero
    output logic                        m_tlast,   // byte_last
    // Configuration.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swsr_pkg::ADDR_W-1:0] paddr,
    input  logic [swsr_pkg::APB_W-1:0]  pwdata,
    output logic [swsr_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);

    swsr_pkg::cfg_t    cfg;
    swsr_pkg::result_t result;
    swsr_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              in_action_reg;
    logic              in_line_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              step;

    // Pipeline control: a word moves on when the output register can take it.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    swsr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swsr_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (step),
        .action     (in_action_reg),
        .line_level (in_line_reg),
        .result     (result)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_line_reg   <= s_tdata[0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    // Result word packing.
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.byte_last;
    assign m_tdata  = {1'b0, out_reg.status, out_reg.status_valid, out_reg.data_byte,
                       out_reg.byte_valid, out_reg.busy_res, out_reg.drive_low};

endmodule
